// ===== design/tlt_pkg.sv =====
package tlt_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_TRANS  = 3'd1,
    OP_ATTEMPT = 3'd2,
    OP_FLOOD  = 3'd3,
    OP_SWEEP  = 3'd4,
    OP_REMOVE = 3'd5
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_CAPACITY  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BAD_STATE = 3'd5;
  localparam logic [2:0] ST_UNAUTH    = 3'd6;

  localparam logic [3:0] SG_PREPARED    = 4'd0;
  localparam logic [3:0] SG_DIRECT      = 4'd1;
  localparam logic [3:0] SG_AWAIT       = 4'd2;
  localparam logic [3:0] SG_RETRY       = 4'd3;
  localparam logic [3:0] SG_FLOOD       = 4'd4;
  localparam logic [3:0] SG_RESPONSE    = 4'd5;
  localparam logic [3:0] SG_CONFIRM     = 4'd6;
  localparam logic [3:0] SG_COMPLETE    = 4'd7;
  localparam logic [3:0] SG_FAILED      = 4'd8;
  localparam logic [3:0] SG_DECLINED    = 4'd9;
  localparam logic [3:0] SG_EXPIRED     = 4'd10;
  localparam logic [3:0] SG_INTERRUPTED = 4'd11;

  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_DECLINE = 3'd4;

  localparam logic [2:0] CFG_FLOOD_LIMIT = 3'd0;

  // entry fields other than the key
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  stage;
    logic [2:0]  flags;
    logic [7:0]  floods;
    logic [2:0]  attempts;
    logic [31:0] created;
    logic [31:0] updated;
    logic [31:0] expires;
  } rec_t;

  function automatic logic is_terminal(input logic [3:0] s);
    return (s >= SG_COMPLETE) && (s <= SG_INTERRUPTED);
  endfunction

  function automatic logic move_ok(input logic [3:0] from, input logic [3:0] to);
    logic ok;
    ok = 1'b0;
    if (from == to) ok = 1'b1;
    else if (is_terminal(from)) ok = 1'b0;
    else if (to == SG_FAILED || to == SG_EXPIRED || to == SG_INTERRUPTED) ok = 1'b1;
    else begin
      unique case (from)
        SG_PREPARED: ok = to == SG_DIRECT || to == SG_AWAIT || to == SG_RETRY ||
                          to == SG_FLOOD || to == SG_COMPLETE;
        SG_DIRECT, SG_RETRY, SG_FLOOD:
          ok = to == SG_AWAIT || to == SG_RETRY || to == SG_FLOOD ||
               to == SG_RESPONSE || to == SG_CONFIRM || to == SG_COMPLETE ||
               to == SG_DECLINED;
        SG_AWAIT: ok = to == SG_RETRY || to == SG_FLOOD || to == SG_RESPONSE ||
                       to == SG_CONFIRM || to == SG_COMPLETE || to == SG_DECLINED;
        SG_RESPONSE: ok = to == SG_CONFIRM || to == SG_COMPLETE || to == SG_DECLINED;
        SG_CONFIRM: ok = to == SG_COMPLETE;
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  function automatic logic [2:0] attempt_limit(input logic [2:0] kind);
    logic [2:0] lim;
    if (kind == KIND_DECLINE) lim = 3'd1;
    else if (kind == KIND_REMOVE) lim = 3'd2;
    else lim = 3'd4;
    return lim;
  endfunction

  // sequencer command to the memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== design/transaction_ledger_table.sv =====
// channel  | dir | beat contents
// in_      | in  | tdata: operation, txn_id, kind, new_stage, flags, timestamp, expiry,
//          |     |        time_trusted (from bit 0 up)
// out_     | out | tdata: status, changed_count, entries_in_use (from bit 0 up)
// cfg_     | in  | apb register flood_limit at address 0
// one beat per operation; a search, sweep or compaction walks the table slot by slot
// through the entry memory
// rst_n is synchronous; it sets flood_limit to 1 and clears the live count and the handshakes
// the result waits in an output register; the next beat is taken once it is delivered
module transaction_ledger_table #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // operation, txn_id, kind, new_stage, flags, timestamp,
                                   // expiry, time_trusted
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // status, changed_count, entries_in_use
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [1:0] CFG_ADDR_FLOOD = 2'(tlt_pkg::CFG_FLOOD_LIMIT * 4);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,  // read slot idx
    S_CHECK  = 6'b000100,  // data of slot idx back
    S_SHIFT  = 6'b001000,  // compaction read/write
    S_SWEEP  = 6'b010000,
    S_DONE   = 6'b100000
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;

  // config
  logic [7:0] flood_limit_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == CFG_ADDR_FLOOD);
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_FLOOD) ? {24'd0, flood_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) flood_limit_r <= 8'd1;
    else if (cfg_wr) flood_limit_r <= cfg_pwdata[7:0];
  end

  // latched operation
  logic [2:0]           op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [2:0]           kind_r;
  logic [3:0]           stage_r;
  logic [2:0]           flags_r;
  logic [31:0]          ts_r, exp_r;

  logic [CW-1:0] live_r;
  logic [CW-1:0] idx_r, idx_nxt;   // slot being read
  logic [CW-1:0] cidx_r;           // slot whose data is on the read port
  logic [2:0]    status_r;
  logic [4:0]    changed_r;
  logic          ovalid_r;

  tlt_pkg::mem_ctl_t ctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_key, rd_key;
  tlt_pkg::rec_t wr_rec, rd_rec, new_rec;

  tlt_mem #(.DEPTH(CAPACITY), .AW(AW), .KW(KEY_BITS)) u_mem (
    .clk(clk), .ctl(ctl), .rd_addr(rd_addr), .wr_addr(wr_addr),
    .wr_key(wr_key), .wr_rec(wr_rec), .rd_key(rd_key), .rd_rec(rd_rec)
  );

  assign in_tready = (fsm_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {3'd0, 5'(live_r), changed_r, status_r};

  logic accept;
  assign accept = in_tvalid && in_tready;

  logic hit;
  assign hit = (rd_key == key_r);

  logic expired_now;
  assign expired_now = !tlt_pkg::is_terminal(rd_rec.stage) && (rd_rec.expires != 32'd0) &&
                       (ts_r >= rd_rec.expires);

  logic begin_bad;
  assign begin_bad = (key_r == '0) || (kind_r > 3'd5) ||
                     ((exp_r != 32'd0) && (ts_r != 32'd0) && (exp_r <= ts_r));

  logic [2:0]  status_nxt;
  logic [4:0]  changed_nxt;
  logic [CW-1:0] live_nxt;
  logic done_now;

  always_comb begin
    fsm_nxt = fsm_r;
    idx_nxt = idx_r;
    ctl = '0;
    rd_addr = idx_r[AW-1:0];
    wr_addr = cidx_r[AW-1:0];
    wr_key = rd_key;
    wr_rec = rd_rec;
    new_rec = rd_rec;
    status_nxt = status_r;
    changed_nxt = changed_r;
    live_nxt = live_r;
    done_now = 1'b0;
    unique case (fsm_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          changed_nxt = 5'd0;
          status_nxt = tlt_pkg::ST_OK;
          unique case (in_tdata[2:0])
            tlt_pkg::OP_SWEEP: begin
              if (in_tdata[141] && in_tdata[108:77] != 32'd0) fsm_nxt = S_SEARCH;
              else fsm_nxt = S_DONE;
            end
            tlt_pkg::OP_BEGIN, tlt_pkg::OP_TRANS, tlt_pkg::OP_ATTEMPT,
            tlt_pkg::OP_FLOOD, tlt_pkg::OP_REMOVE: fsm_nxt = S_SEARCH;
            default: begin
              status_nxt = tlt_pkg::ST_INVALID;
              fsm_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (op_r == tlt_pkg::OP_BEGIN && begin_bad) begin
          status_nxt = tlt_pkg::ST_INVALID;
          fsm_nxt = S_DONE;
        end else if (idx_r >= live_r) begin
          // key not present / sweep finished
          if (op_r == tlt_pkg::OP_BEGIN) begin
            if (live_r >= CW'(CAPACITY)) status_nxt = tlt_pkg::ST_CAPACITY;
            else begin
              ctl.wr_en = 1'b1;
              wr_addr = live_r[AW-1:0];
              wr_key = key_r;
              wr_rec.kind = kind_r;
              wr_rec.stage = tlt_pkg::SG_PREPARED;
              wr_rec.flags = flags_r;
              wr_rec.floods = 8'd0;
              wr_rec.attempts = 3'd0;
              wr_rec.created = ts_r;
              wr_rec.updated = ts_r;
              wr_rec.expires = exp_r;
              live_nxt = live_r + 1'b1;
            end
          end else if (op_r != tlt_pkg::OP_SWEEP) begin
            status_nxt = tlt_pkg::ST_NOT_FOUND;
          end
          fsm_nxt = S_DONE;
        end else begin
          ctl.rd_en = 1'b1;
          fsm_nxt = (op_r == tlt_pkg::OP_SWEEP) ? S_SWEEP : S_CHECK;
        end
      end
      S_SWEEP: begin
        if (expired_now) begin
          new_rec.stage = tlt_pkg::SG_EXPIRED;
          new_rec.updated = ts_r;
          wr_rec = new_rec;
          ctl.wr_en = 1'b1;
          changed_nxt = changed_r + 5'd1;
        end
        idx_nxt = idx_r + 1'b1;
        fsm_nxt = S_SEARCH;
      end
      S_CHECK: begin
        idx_nxt = idx_r + 1'b1;
        if (!hit) fsm_nxt = S_SEARCH;
        else begin
          fsm_nxt = S_DONE;
          unique case (op_r)
            tlt_pkg::OP_BEGIN: status_nxt = tlt_pkg::ST_DUPLICATE;
            tlt_pkg::OP_TRANS: begin
              if (stage_r > tlt_pkg::SG_INTERRUPTED ||
                  !tlt_pkg::move_ok(rd_rec.stage, stage_r))
                status_nxt = tlt_pkg::ST_BAD_STATE;
              else begin
                new_rec.stage = stage_r;
                new_rec.updated = ts_r;
                wr_rec = new_rec;
                ctl.wr_en = 1'b1;
              end
            end
            tlt_pkg::OP_ATTEMPT: begin
              if (tlt_pkg::is_terminal(rd_rec.stage) ||
                  rd_rec.attempts >= tlt_pkg::attempt_limit(rd_rec.kind))
                status_nxt = tlt_pkg::ST_CAPACITY;
              else begin
                new_rec.attempts = rd_rec.attempts + 3'd1;
                new_rec.updated = ts_r;
                wr_rec = new_rec;
                ctl.wr_en = 1'b1;
              end
            end
            tlt_pkg::OP_FLOOD: begin
              if (rd_rec.flags[1:0] != 2'b11 || rd_rec.floods >= flood_limit_r ||
                  rd_rec.kind > 3'd3)
                status_nxt = tlt_pkg::ST_UNAUTH;
              else begin
                new_rec.floods = rd_rec.floods + 8'd1;
                new_rec.updated = ts_r;
                wr_rec = new_rec;
                ctl.wr_en = 1'b1;
              end
            end
            default: begin
              // remove: shift later entries down
              if (idx_nxt >= live_r) begin
                live_nxt = live_r - 1'b1;
                fsm_nxt = S_DONE;
              end else begin
                rd_addr = idx_nxt[AW-1:0];
                ctl.rd_en = 1'b1;
                fsm_nxt = S_SHIFT;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // rd data is slot cidx; write it to cidx-1
        ctl.wr_en = 1'b1;
        wr_addr = AW'(cidx_r - 1'b1);
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt >= live_r) begin
          live_nxt = live_r - 1'b1;
          fsm_nxt = S_DONE;
        end else begin
          rd_addr = idx_nxt[AW-1:0];
          ctl.rd_en = 1'b1;
        end
      end
      S_DONE: begin
        done_now = 1'b1;
        fsm_nxt = S_IDLE;
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= S_IDLE;
      live_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      live_r <= live_nxt;
      if (done_now) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    status_r <= status_nxt;
    changed_r <= changed_nxt;
    if (ctl.rd_en) cidx_r <= rd_addr == idx_nxt[AW-1:0] ? idx_nxt : idx_r;
    if (accept) begin
      op_r <= in_tdata[2:0];
      key_r <= in_tdata[3 +: KEY_BITS];
      kind_r <= in_tdata[69:67];
      stage_r <= in_tdata[73:70];
      flags_r <= in_tdata[76:74];
      ts_r <= in_tdata[108:77];
      exp_r <= in_tdata[140:109];
    end
  end

`ifndef SYNTHESIS
  a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(CAPACITY)) else $error("live count over capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("accepted while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done_now |=> out_tvalid) else $error("result lost");
  a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != $past(live_r)) |-> ($past(fsm_r) != S_IDLE)) else $error("live moved idle");
`endif

endmodule

// ===== design/tlt_mem.sv =====
module tlt_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4,
  parameter int KW = 64
) (
  input  logic                clk,
  input  tlt_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [KW-1:0]       wr_key,
  input  tlt_pkg::rec_t       wr_rec,
  output logic [KW-1:0]       rd_key,
  output tlt_pkg::rec_t       rd_rec
);

  logic [KW-1:0]  key_mem [DEPTH];
  tlt_pkg::rec_t  rec_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      rec_mem[wr_addr] <= wr_rec;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_rec <= rec_mem[rd_addr];
    end
  end

endmodule

// ===== tb/tb_transaction_ledger_table.sv =====
module tb_transaction_ledger_table;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 64;
  localparam int KEY_POOL = 20;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  // operation codes outside the defined set, and stage, kind and flag values used by the bench
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam logic [3:0] SG_UNDEF = 4'd12;
  localparam logic [2:0] KIND_REQUEST = 3'd0;
  localparam logic [2:0] KIND_UNDEF = 3'd7;
  localparam logic [2:0] FLAG_INIT_FLOOD = 3'b011;
  localparam logic [2:0] FLAG_ALL = 3'b111;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] txn_id;
    logic [2:0]  kind;
    logic [3:0]  new_stage;
    logic [2:0]  flags;
    logic [31:0] timestamp;
    logic [31:0] expiry;
    logic        time_trusted;
  } ledger_op_t;

  typedef struct {
    logic [2:0] status;
    logic [4:0] changed;
    logic [4:0] in_use;
  } ledger_resp_t;

  // a directed row: the response is typed in only where it is obvious
  typedef struct {
    ledger_op_t   cmd;
    bit           fixed;
    ledger_resp_t resp;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;   // operation, txn_id, kind, new_stage, flags, timestamp,
                            // expiry, time_trusted
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;  // status, changed_count, entries_in_use
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [1:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  transaction_ledger_table #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // shadow copy of the ledger
  logic [63:0]    shadow_key[CAPACITY];
  tlt_pkg::rec_t  shadow_rec[CAPACITY];
  int             shadow_live;
  logic [7:0]     shadow_flood_limit;

  ledger_resp_t pending_resp[$];
  logic [63:0]  key_pool[KEY_POOL];
  logic [31:0]  now_ts;

  int  mismatches;
  int  beats_in;
  int  beats_out;
  int  sweep_hits;
  int  status_seen[8];
  int  quiet_cycles;
  bit  no_idle;
  bit  hold_req;

  function automatic int find_slot(input logic [63:0] key);
    for (int i = 0; i < shadow_live; i++)
      if (shadow_key[i] == key) return i;
    return -1;
  endfunction

  function automatic bit stage_final(input logic [3:0] s);
    return s >= tlt_pkg::SG_COMPLETE && s <= tlt_pkg::SG_INTERRUPTED;
  endfunction

  // legal stage moves of one entry
  function automatic bit stage_move_legal(input logic [3:0] from, input logic [3:0] to);
    if (from == to) return 1'b1;
    if (stage_final(from)) return 1'b0;
    if (to == tlt_pkg::SG_FAILED || to == tlt_pkg::SG_EXPIRED ||
        to == tlt_pkg::SG_INTERRUPTED) return 1'b1;
    case (from)
      tlt_pkg::SG_PREPARED:
        return to inside {tlt_pkg::SG_DIRECT, tlt_pkg::SG_AWAIT, tlt_pkg::SG_RETRY,
                          tlt_pkg::SG_FLOOD, tlt_pkg::SG_COMPLETE};
      tlt_pkg::SG_DIRECT, tlt_pkg::SG_RETRY, tlt_pkg::SG_FLOOD:
        return to inside {tlt_pkg::SG_AWAIT, tlt_pkg::SG_RETRY, tlt_pkg::SG_FLOOD,
                          tlt_pkg::SG_RESPONSE, tlt_pkg::SG_CONFIRM,
                          tlt_pkg::SG_COMPLETE, tlt_pkg::SG_DECLINED};
      tlt_pkg::SG_AWAIT:
        return to inside {tlt_pkg::SG_RETRY, tlt_pkg::SG_FLOOD, tlt_pkg::SG_RESPONSE,
                          tlt_pkg::SG_CONFIRM, tlt_pkg::SG_COMPLETE,
                          tlt_pkg::SG_DECLINED};
      tlt_pkg::SG_RESPONSE:
        return to inside {tlt_pkg::SG_CONFIRM, tlt_pkg::SG_COMPLETE, tlt_pkg::SG_DECLINED};
      tlt_pkg::SG_CONFIRM: return to == tlt_pkg::SG_COMPLETE;
      default:             return 1'b0;
    endcase
  endfunction

  function automatic int max_attempts(input logic [2:0] kind);
    if (kind == tlt_pkg::KIND_DECLINE) return 1;
    if (kind == tlt_pkg::KIND_REMOVE) return 2;
    return 4;
  endfunction

  // applies one operation to the shadow ledger and returns its response
  function automatic ledger_resp_t ledger_apply(input ledger_op_t c);
    ledger_resp_t r;
    int slot;
    logic [63:0] key;
    key = c.txn_id & ({64{1'b1}} >> (64 - KEY_BITS));
    r.status = tlt_pkg::ST_OK;
    r.changed = '0;
    slot = find_slot(key);
    case (c.op)
      tlt_pkg::OP_BEGIN: begin
        if (key == '0 || c.kind > 3'd5 ||
            (c.expiry != '0 && c.timestamp != '0 && c.expiry <= c.timestamp))
          r.status = tlt_pkg::ST_INVALID;
        else if (slot >= 0) r.status = tlt_pkg::ST_DUPLICATE;
        else if (shadow_live >= CAPACITY) r.status = tlt_pkg::ST_CAPACITY;
        else begin
          shadow_key[shadow_live] = key;
          shadow_rec[shadow_live] = '{kind: c.kind, stage: tlt_pkg::SG_PREPARED,
                                      flags: c.flags, floods: '0, attempts: '0,
                                      created: c.timestamp, updated: c.timestamp,
                                      expires: c.expiry};
          shadow_live++;
        end
      end
      tlt_pkg::OP_TRANS: begin
        if (slot < 0) r.status = tlt_pkg::ST_NOT_FOUND;
        else if (c.new_stage > tlt_pkg::SG_INTERRUPTED ||
                 !stage_move_legal(shadow_rec[slot].stage, c.new_stage))
          r.status = tlt_pkg::ST_BAD_STATE;
        else begin
          shadow_rec[slot].stage = c.new_stage;
          shadow_rec[slot].updated = c.timestamp;
        end
      end
      tlt_pkg::OP_ATTEMPT: begin
        if (slot < 0) r.status = tlt_pkg::ST_NOT_FOUND;
        else if (stage_final(shadow_rec[slot].stage) ||
                 shadow_rec[slot].attempts >= max_attempts(shadow_rec[slot].kind))
          r.status = tlt_pkg::ST_CAPACITY;
        else begin
          shadow_rec[slot].attempts++;
          shadow_rec[slot].updated = c.timestamp;
        end
      end
      tlt_pkg::OP_FLOOD: begin
        if (slot < 0) r.status = tlt_pkg::ST_NOT_FOUND;
        else if ((shadow_rec[slot].flags & FLAG_INIT_FLOOD) != FLAG_INIT_FLOOD ||
                 shadow_rec[slot].floods >= shadow_flood_limit ||
                 shadow_rec[slot].kind > 3'd3)
          r.status = tlt_pkg::ST_UNAUTH;
        else begin
          shadow_rec[slot].floods++;
          shadow_rec[slot].updated = c.timestamp;
        end
      end
      tlt_pkg::OP_SWEEP: begin
        if (c.time_trusted && c.timestamp != '0) begin
          for (int i = 0; i < shadow_live; i++) begin
            if (!stage_final(shadow_rec[i].stage) && shadow_rec[i].expires != '0 &&
                c.timestamp >= shadow_rec[i].expires) begin
              shadow_rec[i].stage = tlt_pkg::SG_EXPIRED;
              shadow_rec[i].updated = c.timestamp;
              r.changed++;
            end
          end
        end
      end
      tlt_pkg::OP_REMOVE: begin
        if (slot < 0) r.status = tlt_pkg::ST_NOT_FOUND;
        else begin
          for (int i = slot; i + 1 < shadow_live; i++) begin
            shadow_key[i] = shadow_key[i + 1];
            shadow_rec[i] = shadow_rec[i + 1];
          end
          shadow_live--;
        end
      end
      default: r.status = tlt_pkg::ST_INVALID;
    endcase
    r.in_use = shadow_live[4:0];
    return r;
  endfunction

  // random operation, mostly on a small pool of ids so entries get revisited
  function automatic ledger_op_t random_op();
    ledger_op_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 26) c.op = tlt_pkg::OP_BEGIN;
    else if (pick < 52) c.op = tlt_pkg::OP_TRANS;
    else if (pick < 66) c.op = tlt_pkg::OP_ATTEMPT;
    else if (pick < 78) c.op = tlt_pkg::OP_FLOOD;
    else if (pick < 85) c.op = tlt_pkg::OP_SWEEP;
    else if (pick < 97) c.op = tlt_pkg::OP_REMOVE;
    else c.op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
    c.txn_id = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(KEY_POOL - 1)];
    c.kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    c.new_stage = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 12))
                                           : 4'($urandom_range(11));
    c.flags = ($urandom_range(1)) ? FLAG_INIT_FLOOD | 3'($urandom_range(7))
                                  : 3'($urandom_range(7));
    now_ts += $urandom_range(40);
    case ($urandom_range(19))
      0:       c.timestamp = '0;
      1:       c.timestamp = $urandom;
      2:       c.timestamp = '1;
      default: c.timestamp = now_ts;
    endcase
    case ($urandom_range(9))
      0, 1, 2: c.expiry = '0;
      3:       c.expiry = $urandom;
      4:       c.expiry = c.timestamp;
      default: c.expiry = now_ts + $urandom_range(1, 200);
    endcase
    c.time_trusted = ($urandom_range(4) != 0);
    return c;
  endfunction

  task automatic offer_beat(input ledger_op_t c, input bit fixed, input ledger_resp_t want);
    ledger_resp_t got;
    if (!no_idle && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, c.time_trusted, c.expiry, c.timestamp, c.flags, c.new_stage,
                  c.kind, c.txn_id, c.op};
    do @(posedge clk); while (!in_tready);
    beats_in++;
    got = ledger_apply(c);
    pending_resp.push_back(fixed ? want : got);
  endtask

  // register writes only with the table idle
  task automatic write_flood_limit(input logic [7:0] value);
    in_tvalid <= 1'b0;
    wait (pending_resp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 2'(tlt_pkg::CFG_FLOOD_LIMIT * 4);
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    shadow_flood_limit = value;
  endtask

  // response checker
  always @(posedge clk) begin
    ledger_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat %h", out_tdata);
      end else begin
        want = pending_resp.pop_front();
        status_seen[out_tdata[2:0]]++;
        if (out_tdata[7:3] != 5'd0) sweep_hits++;
        if (out_tdata[2:0] != want.status || out_tdata[7:3] != want.changed ||
            out_tdata[12:8] != want.in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: status %0d/%0d changed %0d/%0d in_use %0d/%0d",
                     beats_out, want.status, out_tdata[2:0], want.changed,
                     out_tdata[7:3], want.in_use, out_tdata[12:8]);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 25);
      end
    end
  end

  // watchdog on progress of either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t      rows[$];
    ledger_resp_t  none;
    logic [63:0]   all_ones;
    logic [7:0]    limits[5];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    mismatches  = 0;
    beats_in    = 0;
    beats_out   = 0;
    sweep_hits  = 0;
    quiet_cycles = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    shadow_live = 0;
    shadow_flood_limit = 8'd1;
    now_ts = 32'd1000;
    none = '{default: '0};
    all_ones = '1;
    key_pool[0] = all_ones;
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;

    // directed rows: op, id, kind, stage, flags, ts, expiry, trusted
    rows = '{
      // sweep on an empty table
      '{'{tlt_pkg::OP_SWEEP, 64'd0, 3'd0, 4'd0, 3'd0, 32'd100, 32'd0, 1'b1}, 1,
        '{tlt_pkg::ST_OK, 0, 0}},
      // begin rejects a zero id, a bad kind and an expiry not after creation
      '{'{tlt_pkg::OP_BEGIN, 64'd0, 3'd0, 4'd0, 3'd0, 32'd5, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_INVALID, 0, 0}},
      '{'{tlt_pkg::OP_BEGIN, 64'd9, KIND_UNDEF, 4'd0, 3'd0, 32'd5, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_INVALID, 0, 0}},
      '{'{tlt_pkg::OP_BEGIN, 64'd9, 3'd0, 4'd0, 3'd0, 32'd100, 32'd100, 1'b0}, 1,
        '{tlt_pkg::ST_INVALID, 0, 0}},
      '{'{tlt_pkg::OP_TRANS, 64'd5, 3'd0, 4'd1, 3'd0, 32'd1, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_NOT_FOUND, 0, 0}},
      '{'{OP_UNDEF_LO, 64'd5, 3'd0, 4'd0, 3'd0, 32'd1, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_INVALID, 0, 0}},
      '{'{OP_UNDEF_HI, all_ones, KIND_UNDEF, 4'hf, FLAG_ALL, 32'hffff_ffff, 32'hffff_ffff,
          1'b1}, 1, '{tlt_pkg::ST_INVALID, 0, 0}},
      // full-width id, expiring request with flood rights
      '{'{tlt_pkg::OP_BEGIN, all_ones, KIND_REQUEST, 4'd0, FLAG_INIT_FLOOD, 32'd0, 32'd50,
          1'b0}, 1, '{tlt_pkg::ST_OK, 0, 1}},
      '{'{tlt_pkg::OP_BEGIN, all_ones, KIND_REQUEST, 4'd0, 3'd0, 32'd1, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_DUPLICATE, 0, 1}},
      // decline kind: a single direct attempt
      '{'{tlt_pkg::OP_BEGIN, 64'd1, tlt_pkg::KIND_DECLINE, 4'd0, FLAG_ALL, 32'd10, 32'd0,
          1'b0}, 1, '{tlt_pkg::ST_OK, 0, 2}},
      '{'{tlt_pkg::OP_ATTEMPT, 64'd1, 3'd0, 4'd0, 3'd0, 32'd11, 32'd0, 1'b0}, 0, none},
      '{'{tlt_pkg::OP_ATTEMPT, 64'd1, 3'd0, 4'd0, 3'd0, 32'd12, 32'd0, 1'b0}, 0, none},
      // decline kind never floods, request floods up to the limit
      '{'{tlt_pkg::OP_FLOOD, 64'd1, 3'd0, 4'd0, 3'd0, 32'd13, 32'd0, 1'b0}, 0, none},
      '{'{tlt_pkg::OP_FLOOD, all_ones, 3'd0, 4'd0, 3'd0, 32'd14, 32'd0, 1'b0}, 0, none},
      '{'{tlt_pkg::OP_FLOOD, all_ones, 3'd0, 4'd0, 3'd0, 32'd15, 32'd0, 1'b0}, 0, none},
      '{'{tlt_pkg::OP_TRANS, all_ones, 3'd0, SG_UNDEF, 3'd0, 32'd16, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_BAD_STATE, 0, 2}},
      '{'{tlt_pkg::OP_TRANS, all_ones, 3'd0, tlt_pkg::SG_DIRECT, 3'd0, 32'd17, 32'd0,
          1'b0}, 0, none},
      // untrusted time leaves everything alone, trusted time expires the first entry
      '{'{tlt_pkg::OP_SWEEP, 64'd0, 3'd0, 4'd0, 3'd0, 32'd60, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_OK, 0, 2}},
      '{'{tlt_pkg::OP_SWEEP, 64'd0, 3'd0, 4'd0, 3'd0, 32'd60, 32'd0, 1'b1}, 1,
        '{tlt_pkg::ST_OK, 1, 2}},
      '{'{tlt_pkg::OP_TRANS, all_ones, 3'd0, tlt_pkg::SG_PREPARED, 3'd0, 32'd61, 32'd0,
          1'b0}, 1, '{tlt_pkg::ST_BAD_STATE, 0, 2}},
      '{'{tlt_pkg::OP_ATTEMPT, all_ones, 3'd0, 4'd0, 3'd0, 32'd62, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_CAPACITY, 0, 2}},
      '{'{tlt_pkg::OP_REMOVE, 64'd1, 3'd0, 4'd0, 3'd0, 32'd63, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_OK, 0, 1}},
      '{'{tlt_pkg::OP_REMOVE, 64'd1, 3'd0, 4'd0, 3'd0, 32'd64, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_NOT_FOUND, 0, 1}},
      '{'{tlt_pkg::OP_REMOVE, all_ones, 3'd0, 4'd0, 3'd0, 32'd65, 32'd0, 1'b0}, 1,
        '{tlt_pkg::ST_OK, 0, 0}}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) offer_beat(rows[i].cmd, rows[i].fixed, rows[i].resp);

    // phases over the flood limit, reset value first
    limits = '{8'd1, 8'd0, 8'd255, 8'd2, 8'($urandom_range(3, 254))};
    foreach (limits[p]) begin
      if (p != 0) write_flood_limit(limits[p]);
      if (p == 1) hold_req = 1'b1;
      no_idle = (p == 3);
      for (int n = 0; n < 310; n++) offer_beat(random_op(), 1'b0, none);
    end
    in_tvalid <= 1'b0;

    wait (pending_resp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations over five flood limits, %0d responses, %0d sweeps expired",
             beats_in, beats_out, sweep_hits);
    $display("status mix ok/inval/dup/full/absent/state/unauth: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
